[rtl/core/albd_pkg.sv]
// Shared types and constants for the ADC ladder button debouncer.
// Used by every module in rtl/core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package albd_pkg;

   // ADC reading width
   localparam int ADC_BITS  = 12;
   localparam int MASK_BITS = 7;
   localparam int TIME_BITS = 32;
   localparam int DEB_BITS  = 16;

   localparam int BANDS_A   = 4;
   localparam int BANDS_B   = 2;
   localparam int B_LSB     = BANDS_A;
   localparam int POWER_BIT = BANDS_A + BANDS_B;

   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = (ADC_BITS > DEB_BITS) ? ADC_BITS : DEB_BITS;

   localparam int REQ_FIELD_BITS = 2 * ADC_BITS + 1 + TIME_BITS;
   localparam int REQ_TDATA_BITS = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 3 * MASK_BITS + 2 + TIME_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_LADDER_A_TOP = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_LADDER_A_T1  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_LADDER_A_T2  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_LADDER_A_T3  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_LADDER_B_TOP = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_LADDER_B_T1  = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_DEBOUNCE_MS  = 3'd6;

   // reset values
   localparam logic [ADC_BITS-1:0] RST_LADDER_A_TOP = ADC_BITS'(3999);
   localparam logic [ADC_BITS-1:0] RST_LADDER_A_T1  = ADC_BITS'(3260);
   localparam logic [ADC_BITS-1:0] RST_LADDER_A_T2  = ADC_BITS'(2408);
   localparam logic [ADC_BITS-1:0] RST_LADDER_A_T3  = ADC_BITS'(1194);
   localparam logic [ADC_BITS-1:0] RST_LADDER_B_TOP = ADC_BITS'(2583);
   localparam logic [ADC_BITS-1:0] RST_LADDER_B_T1  = ADC_BITS'(1944);
   localparam logic [DEB_BITS-1:0] RST_DEBOUNCE_MS  = DEB_BITS'(5);

   typedef struct packed {
      logic                     en;
      logic [CSR_IDX_BITS-1:0]  index;
      logic [CSR_DATA_BITS-1:0] data;
   } csr_wr_type;

   // one classified sample tick
   typedef struct packed {
      logic [MASK_BITS-1:0] raw;
      logic [TIME_BITS-1:0] now;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] held_ms;
      logic                 any_released;
      logic                 any_pressed;
      logic [MASK_BITS-1:0] released_mask;
      logic [MASK_BITS-1:0] pressed_mask;
      logic [MASK_BITS-1:0] stable_mask;
   } result_type;

endpackage

`default_nettype wire

[rtl/core/albd_front.sv]
// Front end: ladder threshold registers and band classification into a raw mask.
// Depends on albd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module albd_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire albd_pkg::csr_wr_type          csr,
   input  wire logic [albd_pkg::ADC_BITS-1:0] adc_a,
   input  wire logic [albd_pkg::ADC_BITS-1:0] adc_b,
   input  wire logic                          power_level,
   input  wire logic [albd_pkg::TIME_BITS-1:0] now_ms,
   output albd_pkg::item_type                 item
);

   logic [albd_pkg::ADC_BITS-1:0] bound_a_ff [albd_pkg::BANDS_A];
   logic [albd_pkg::ADC_BITS-1:0] bound_b_ff [albd_pkg::BANDS_B];
   logic [albd_pkg::ADC_BITS-1:0] wr_value;
   logic [albd_pkg::BANDS_A-1:0]  hit_a;
   logic [albd_pkg::BANDS_B-1:0]  hit_b;
   logic                          found_a;
   logic                          found_b;

   assign wr_value = csr.data[albd_pkg::ADC_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         bound_a_ff[0] <= albd_pkg::RST_LADDER_A_TOP;
         bound_a_ff[1] <= albd_pkg::RST_LADDER_A_T1;
         bound_a_ff[2] <= albd_pkg::RST_LADDER_A_T2;
         bound_a_ff[3] <= albd_pkg::RST_LADDER_A_T3;
         bound_b_ff[0] <= albd_pkg::RST_LADDER_B_TOP;
         bound_b_ff[1] <= albd_pkg::RST_LADDER_B_T1;
      end else if (csr.en) begin
         unique case (csr.index)
            albd_pkg::REG_LADDER_A_TOP: bound_a_ff[0] <= wr_value;
            albd_pkg::REG_LADDER_A_T1:  bound_a_ff[1] <= wr_value;
            albd_pkg::REG_LADDER_A_T2:  bound_a_ff[2] <= wr_value;
            albd_pkg::REG_LADDER_A_T3:  bound_a_ff[3] <= wr_value;
            albd_pkg::REG_LADDER_B_TOP: bound_b_ff[0] <= wr_value;
            albd_pkg::REG_LADDER_B_T1:  bound_b_ff[1] <= wr_value;
            default: ;
         endcase
      end
   end

   // first band (bound[i+1] < v <= bound[i]) wins; lowest band open below
   always_comb begin
      found_a = 1'b0;
      hit_a   = '0;
      for (int i = 0; i < albd_pkg::BANDS_A - 1; i++) begin
         if (!found_a && (bound_a_ff[i + 1] < adc_a) && (adc_a <= bound_a_ff[i])) begin
            hit_a[i] = 1'b1;
            found_a  = 1'b1;
         end
      end
      if (!found_a && (adc_a <= bound_a_ff[albd_pkg::BANDS_A - 1])) begin
         hit_a[albd_pkg::BANDS_A - 1] = 1'b1;
         found_a                      = 1'b1;
      end
      found_b = 1'b0;
      hit_b   = '0;
      for (int i = 0; i < albd_pkg::BANDS_B - 1; i++) begin
         if (!found_b && (bound_b_ff[i + 1] < adc_b) && (adc_b <= bound_b_ff[i])) begin
            hit_b[i] = 1'b1;
            found_b  = 1'b1;
         end
      end
      if (!found_b && (adc_b <= bound_b_ff[albd_pkg::BANDS_B - 1])) begin
         hit_b[albd_pkg::BANDS_B - 1] = 1'b1;
         found_b                      = 1'b1;
      end
   end

   assign item.raw = {~power_level, hit_b, hit_a};
   assign item.now = now_ms;

endmodule

`default_nettype wire

[rtl/core/albd_queue.sv]
// Two-entry queue between the classifier and the debounce back end.
// Depends on albd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module albd_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire albd_pkg::item_type       push_item,
   input  wire logic                     pop,
   output albd_pkg::item_type            pop_item,
   output albd_pkg::queue_status_type    status
);

   albd_pkg::item_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign pop_item     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

[rtl/core/albd_back.sv]
// Back end: debounce state, press timing and the registered result beat.
// Depends on albd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module albd_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire albd_pkg::csr_wr_type csr,
   input  wire albd_pkg::item_type   item,
   input  wire logic                 item_valid,
   output logic                      item_pop,
   output albd_pkg::result_type      result,
   output logic                      result_valid,
   input  wire logic                 result_ready
);

   logic [albd_pkg::DEB_BITS-1:0]  debounce_ff;
   logic [albd_pkg::MASK_BITS-1:0] raw_prev_ff, raw_prev_in;
   logic [albd_pkg::TIME_BITS-1:0] change_stamp_ff, change_stamp_in;
   logic [albd_pkg::MASK_BITS-1:0] stable_ff, stable_in;
   logic [albd_pkg::TIME_BITS-1:0] start_ff, start_in;
   logic [albd_pkg::TIME_BITS-1:0] finish_ff, finish_in;
   logic                           valid_ff;
   albd_pkg::result_type           result_ff, result_in;
   logic [albd_pkg::TIME_BITS-1:0] steady_ms;
   logic [albd_pkg::MASK_BITS-1:0] pressed;
   logic [albd_pkg::MASK_BITS-1:0] released;
   logic                           changed;
   logic                           accept;

   assign item_pop     = item_valid && (!valid_ff || result_ready);
   assign result       = result_ff;
   assign result_valid = valid_ff;

   always_comb begin
      changed         = (item.raw != raw_prev_ff);
      raw_prev_in     = item.raw;
      change_stamp_in = changed ? item.now : change_stamp_ff;
      // a fresh change is never accepted, whatever the steady time
      steady_ms       = item.now - change_stamp_ff;
      accept          = !changed
                        && (steady_ms > {{(albd_pkg::TIME_BITS - albd_pkg::DEB_BITS){1'b0}},
                                         debounce_ff})
                        && (item.raw != stable_ff);
      pressed   = '0;
      released  = '0;
      stable_in = stable_ff;
      start_in  = start_ff;
      finish_in = finish_ff;
      if (accept) begin
         pressed   = item.raw & ~stable_ff;
         released  = stable_ff & ~item.raw;
         stable_in = item.raw;
         if ((pressed != '0) && (stable_ff == '0)) begin
            start_in = item.now;
         end
         if ((released != '0) && (item.raw == '0)) begin
            finish_in = item.now;
         end
      end
      result_in.stable_mask   = stable_in;
      result_in.pressed_mask  = pressed;
      result_in.released_mask = released;
      result_in.any_pressed   = (pressed != '0);
      result_in.any_released  = (released != '0);
      result_in.held_ms       = (stable_in != '0) ? (item.now - start_in)
                                                  : (finish_in - start_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= albd_pkg::RST_DEBOUNCE_MS;
      end else if (csr.en && (csr.index == albd_pkg::REG_DEBOUNCE_MS)) begin
         debounce_ff <= csr.data[albd_pkg::DEB_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_prev_ff     <= '0;
         change_stamp_ff <= '0;
         stable_ff       <= '0;
         start_ff        <= '0;
         finish_ff       <= '0;
         valid_ff        <= 1'b0;
      end else begin
         if (item_pop) begin
            raw_prev_ff     <= raw_prev_in;
            change_stamp_ff <= change_stamp_in;
            stable_ff       <= stable_in;
            start_ff        <= start_in;
            finish_ff       <= finish_in;
            valid_ff        <= 1'b1;
         end else if (result_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         result_ff <= result_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/adc_ladder_button_debouncer.sv]
// A beat taken on req_ is classified in the accept cycle and queued; the debounce update
// writes the registered result offered on rsp_. Throughput: one beat per cycle while
// rsp_ is not stalled; queue plus result register hold three stalled beats.
// Reset (synchronous, active high) restores the default thresholds and debounce
// time, clears debounce/press state, empties the queue and drops rsp_tvalid.
`timescale 1ns / 1ps
`default_nettype none

module adc_ladder_button_debouncer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // tdata: adc_a, adc_b, power_level, now_ms, zero pad (lowest bit first)
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [albd_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   // tdata: stable_mask, pressed_mask, released_mask, any_pressed,
   //        any_released, held_ms, zero pad (lowest bit first)
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [albd_pkg::RSP_TDATA_BITS-1:0]      rsp_tdata,
   input  wire logic                                csr_we,
   input  wire logic [albd_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [albd_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int A_LSB   = 0;
   localparam int B_LSB   = albd_pkg::ADC_BITS;
   localparam int PWR_BIT = 2 * albd_pkg::ADC_BITS;
   localparam int NOW_LSB = PWR_BIT + 1;

   albd_pkg::csr_wr_type       csr;
   albd_pkg::item_type         front_item;
   albd_pkg::item_type         queue_item;
   albd_pkg::queue_status_type q_status;
   albd_pkg::result_type       result;
   logic                       push;
   logic                       pop;

   assign csr.en    = csr_we;
   assign csr.index = csr_index;
   assign csr.data  = csr_wdata;

   // the queue decouples input acceptance from output back-pressure
   assign req_tready = !q_status.full;
   assign push       = req_tvalid && req_tready;

   albd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr         (csr),
      .adc_a       (req_tdata[A_LSB +: albd_pkg::ADC_BITS]),
      .adc_b       (req_tdata[B_LSB +: albd_pkg::ADC_BITS]),
      .power_level (req_tdata[PWR_BIT]),
      .now_ms      (req_tdata[NOW_LSB +: albd_pkg::TIME_BITS]),
      .item        (front_item)
   );

   albd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (pop),
      .pop_item  (queue_item),
      .status    (q_status)
   );

   albd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr          (csr),
      .item         (queue_item),
      .item_valid   (!q_status.empty),
      .item_pop     (pop),
      .result       (result),
      .result_valid (rsp_tvalid),
      .result_ready (rsp_tready)
   );

   assign rsp_tdata = {{(albd_pkg::RSP_TDATA_BITS - albd_pkg::RSP_FIELD_BITS){1'b0}}, result};

   // a button cannot be pressed and released in the same beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((result.pressed_mask & result.released_mask) == '0))
      else $error("pressed and released masks overlap");

   // pressed bits must land in the stable mask, released bits must leave it
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (((result.pressed_mask & ~result.stable_mask) == '0)
                      && ((result.released_mask & result.stable_mask) == '0)))
      else $error("event masks disagree with stable mask");

   // summary flags follow their masks
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((result.any_pressed == (result.pressed_mask != '0))
                      && (result.any_released == (result.released_mask != '0))))
      else $error("any flags disagree with masks");

   // queue never reads as both full and empty, and never pops when empty
   assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty) && !(pop && q_status.empty))
      else $error("queue status broken");

endmodule

`default_nettype wire

[tb/adc_ladder_button_debouncer_checker.sv]
// Scoreboard for the ADC ladder button debouncer: predicts each tick result
// from accepted req_ beats and CSR writes, then checks rsp_ beats in order.
// Depends on albd_pkg.
`timescale 1ns / 1ps

module adc_ladder_button_debouncer_checker
   import albd_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   input  wire logic                      req_tready,
   input  wire logic [REQ_TDATA_BITS-1:0] req_tdata,
   input  wire logic                      rsp_tvalid,
   input  wire logic                      rsp_tready,
   input  wire logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   input  wire logic                      csr_we,
   input  wire logic [CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                             mismatches,
   output int                             pending
);

   localparam int REPORT_LIMIT = 30;

   // shadow registers
   logic [ADC_BITS-1:0]  a_top, a_t1, a_t2, a_t3, b_top, b_t1;
   logic [DEB_BITS-1:0]  settle_ms;

   // shadow debounce state
   logic [MASK_BITS-1:0] raw_last, debounced;
   logic [TIME_BITS-1:0] change_ms, press_start_ms, press_end_ms;

   result_type           expected_ticks[$];

   initial begin
      mismatches = 0;
      pending    = 0;
   end

   // first band that holds wins; lowest band open below
   function automatic logic [MASK_BITS-1:0] classify(input logic [ADC_BITS-1:0] va, vb,
                                                     input logic pin);
      logic [MASK_BITS-1:0] raw;
      raw = '0;
      if (va > a_t1 && va <= a_top)      raw[0] = 1'b1;
      else if (va > a_t2 && va <= a_t1)  raw[1] = 1'b1;
      else if (va > a_t3 && va <= a_t2)  raw[2] = 1'b1;
      else if (va <= a_t3)               raw[3] = 1'b1;
      if (vb > b_t1 && vb <= b_top)      raw[B_LSB] = 1'b1;
      else if (vb <= b_t1)               raw[B_LSB+1] = 1'b1;
      raw[POWER_BIT] = ~pin;
      return raw;
   endfunction

   task automatic predict_tick(input logic [REQ_TDATA_BITS-1:0] beat, output result_type r);
      logic [ADC_BITS-1:0]  va, vb;
      logic                 pin;
      logic [TIME_BITS-1:0] stamp, elapsed;
      logic [MASK_BITS-1:0] raw;
      va    = beat[ADC_BITS-1:0];
      vb    = beat[2*ADC_BITS-1:ADC_BITS];
      pin   = beat[2*ADC_BITS];
      stamp = beat[2*ADC_BITS+1 +: TIME_BITS];
      raw   = classify(va, vb, pin);
      r     = '0;
      if (raw != raw_last) begin
         change_ms = stamp;
         raw_last  = raw;
      end
      elapsed = stamp - change_ms;
      if (elapsed > TIME_BITS'(settle_ms) && raw != debounced) begin
         r.pressed_mask  = raw & ~debounced;
         r.released_mask = debounced & ~raw;
         if (r.pressed_mask != '0 && debounced == '0) press_start_ms = stamp;
         if (r.released_mask != '0 && raw == '0) press_end_ms = stamp;
         debounced = raw;
      end
      r.stable_mask  = debounced;
      r.any_pressed  = |r.pressed_mask;
      r.any_released = |r.released_mask;
      r.held_ms      = (debounced != '0) ? stamp - press_start_ms
                                         : press_end_ms - press_start_ms;
   endtask

   task automatic compare_field(input string name, input logic [TIME_BITS-1:0] want, got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      result_type seen, want;
      if (reset) begin
         a_top          = RST_LADDER_A_TOP;
         a_t1           = RST_LADDER_A_T1;
         a_t2           = RST_LADDER_A_T2;
         a_t3           = RST_LADDER_A_T3;
         b_top          = RST_LADDER_B_TOP;
         b_t1           = RST_LADDER_B_T1;
         settle_ms      = RST_DEBOUNCE_MS;
         raw_last       = '0;
         debounced      = '0;
         change_ms      = '0;
         press_start_ms = '0;
         press_end_ms   = '0;
         expected_ticks.delete();
      end else begin
         // retire first so a beat taken at this edge never matches itself
         if (rsp_tvalid && rsp_tready) begin
            seen = result_type'(rsp_tdata[RSP_FIELD_BITS-1:0]);
            if (expected_ticks.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: unexpected result beat: expected none, got 0x%0h",
                           $time, seen);
            end else begin
               want = expected_ticks.pop_front();
               compare_field("stable_mask", TIME_BITS'(want.stable_mask),
                             TIME_BITS'(seen.stable_mask));
               compare_field("pressed_mask", TIME_BITS'(want.pressed_mask),
                             TIME_BITS'(seen.pressed_mask));
               compare_field("released_mask", TIME_BITS'(want.released_mask),
                             TIME_BITS'(seen.released_mask));
               compare_field("any_pressed", TIME_BITS'(want.any_pressed),
                             TIME_BITS'(seen.any_pressed));
               compare_field("any_released", TIME_BITS'(want.any_released),
                             TIME_BITS'(seen.any_released));
               compare_field("held_ms", want.held_ms, seen.held_ms);
            end
         end
         if (req_tvalid && req_tready) begin
            predict_tick(req_tdata, want);
            expected_ticks.push_back(want);
         end
         if (csr_we) begin
            case (csr_index)
               REG_LADDER_A_TOP: a_top     = csr_wdata[ADC_BITS-1:0];
               REG_LADDER_A_T1:  a_t1      = csr_wdata[ADC_BITS-1:0];
               REG_LADDER_A_T2:  a_t2      = csr_wdata[ADC_BITS-1:0];
               REG_LADDER_A_T3:  a_t3      = csr_wdata[ADC_BITS-1:0];
               REG_LADDER_B_TOP: b_top     = csr_wdata[ADC_BITS-1:0];
               REG_LADDER_B_T1:  b_t1      = csr_wdata[ADC_BITS-1:0];
               REG_DEBOUNCE_MS:  settle_ms = csr_wdata[DEB_BITS-1:0];
               default: ;
            endcase
         end
      end
      pending = expected_ticks.size();
   end

endmodule

[tb/adc_ladder_button_debouncer_tb.sv]
// Top of the ADC ladder button debouncer bench: clock, reset, CSR programming,
// tick stimulus and back-pressure; verdict from adc_ladder_button_debouncer_checker.
// Depends on albd_pkg, adc_ladder_button_debouncer and the checker module.
`timescale 1ns / 1ps

module adc_ladder_button_debouncer_tb;
   import albd_pkg::*;

   localparam int STALL_LIMIT     = 1000;  // cycles without any beat or CSR write
   localparam int HOLD_OFF_CYCLES = 150;   // long rsp_ stall, well under STALL_LIMIT
   localparam int IDLE_PCT        = 15;
   localparam int DRAIN_CYCLES    = 4;     // settling margin after the drain

   // index past the register file; writes must be dropped
   localparam logic [CSR_IDX_BITS-1:0] REG_UNUSED = 3'd7;

   // directed ticks at reset thresholds (3999/3260/2408/1194, B 2583/1944, 5 ms);
   // each entry is sent twice, the second beat DIR_GAP ms after the first
   localparam logic [0:11][11:0] DIR_A =
      {12'd4095, 12'd3999, 12'd4000, 12'd3260, 12'd3261, 12'd2408,
       12'd2409, 12'd1194, 12'd1195, 12'd0,    12'd4095, 12'd4095};
   localparam logic [0:11][11:0] DIR_B =
      {12'd4095, 12'd4095, 12'd2583, 12'd2584, 12'd1944, 12'd1945,
       12'd0,    12'd4095, 12'd4095, 12'd0,    12'd4095, 12'd4095};
   localparam logic [0:11]       DIR_PIN = 12'b1111_0010_0110;
   // gap of 5 sits exactly on the debounce time (no accept), 0 is a repeated stamp
   localparam logic [0:11][3:0]  DIR_GAP =
      {4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd5, 4'd0, 4'd7, 4'd7};

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   // tdata: adc_a, adc_b, power_level, now_ms, zero pad (lowest bit first)
   logic [REQ_TDATA_BITS-1:0] req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // tdata: stable_mask, pressed_mask, released_mask, any_pressed,
   //        any_released, held_ms, zero pad (lowest bit first)
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      csr_we     = 1'b0;
   logic [CSR_IDX_BITS-1:0]   csr_index  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata  = '0;

   int                        mismatches, pending;
   int                        beats_sent = 0, beats_seen = 0, idle_cycles = 0;

   // stimulus-side copy of the thresholds: A top, t1, t2, t3, then B top, t1
   logic [ADC_BITS-1:0]       bounds [0:5];
   logic [DEB_BITS-1:0]       settle;
   logic [TIME_BITS-1:0]      tick_ms;
   bit                        quiet        = 1'b0;  // no idling on either side
   bit                        hold_off_req = 1'b0;  // ask the receiver for a long stall

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   adc_ladder_button_debouncer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   adc_ladder_button_debouncer_checker tick_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   // beat counts for draining, and the no-progress watchdog
   always @(posedge clock) begin
      if (req_tvalid && req_tready) beats_sent <= beats_sent + 1;
      if (rsp_tvalid && rsp_tready) beats_seen <= beats_seen + 1;
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("adc_ladder_button_debouncer_tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver: random back-pressure, one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // one tick beat at tick_ms; returns at the edge where it is taken
   task automatic send_tick(input logic [ADC_BITS-1:0] a, b, input logic pin);
      logic ready_seen;
      if (!quiet) begin
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_BITS'({tick_ms, pin, b, a});
      do begin
         @(negedge clock);   // ready is settled mid-cycle
         ready_seen = req_tready;
         @(posedge clock);
      end while (!ready_seen);
   endtask

   // stop offering and wait for every outstanding result
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (beats_sent != beats_seen);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // ladder writes carry random junk above bit 11, which must be dropped
   task automatic program_regs(input logic [ADC_BITS-1:0] a_top, a1, a2, a3, b_top, b1,
                               input logic [DEB_BITS-1:0] deb);
      write_reg(REG_LADDER_A_TOP, {4'($urandom), a_top});
      write_reg(REG_LADDER_A_T1,  {4'($urandom), a1});
      write_reg(REG_LADDER_A_T2,  {4'($urandom), a2});
      write_reg(REG_LADDER_A_T3,  {4'($urandom), a3});
      write_reg(REG_LADDER_B_TOP, {4'($urandom), b_top});
      write_reg(REG_LADDER_B_T1,  {4'($urandom), b1});
      write_reg(REG_DEBOUNCE_MS,  deb);
      write_reg(REG_UNUSED,       16'($urandom));
      csr_we <= 1'b0;
      bounds[0] = a_top;
      bounds[1] = a1;
      bounds[2] = a2;
      bounds[3] = a3;
      bounds[4] = b_top;
      bounds[5] = b1;
      settle    = deb;
   endtask

   // descending thresholds, bands all non-empty most of the time
   task automatic program_ordered(input logic [DEB_BITS-1:0] deb);
      logic [ADC_BITS-1:0] a_top, a1, a2, a3, b_top, b1;
      a_top = 12'($urandom_range(3000, 4095));
      a1    = 12'($urandom_range(2000, a_top));
      a2    = 12'($urandom_range(1000, a1));
      a3    = 12'($urandom_range(0, a2));
      b_top = 12'($urandom_range(1500, 4095));
      b1    = 12'($urandom_range(0, b_top));
      program_regs(a_top, a1, a2, a3, b_top, b1, deb);
   endtask

   function automatic logic [ADC_BITS-1:0] near(input logic [ADC_BITS-1:0] bound);
      return bound + 12'($urandom_range(0, 2)) - 12'd1;
   endfunction

   function automatic logic [ADC_BITS-1:0] pick_a();
      case ($urandom_range(0, 5))
         0, 1, 2: return near(bounds[$urandom_range(0, 3)]);
         3:       return 12'($urandom);
         4:       return '0;
         default: return '1;
      endcase
   endfunction

   function automatic logic [ADC_BITS-1:0] pick_b();
      case ($urandom_range(0, 5))
         0, 1, 2: return near(bounds[4 + $urandom_range(0, 1)]);
         3:       return 12'($urandom);
         4:       return '0;
         default: return '1;
      endcase
   endfunction

   // Mostly held presses: a steady level for a few ticks with time moving on
   // about a quarter of the debounce per tick, so masks get accepted; some
   // holds are full releases, some ticks bounce, and a fifth are pure noise.
   task automatic run_ticks(input int count);
      int                  done, hold, k;
      logic [ADC_BITS-1:0] a, b;
      logic                pin;
      done = 0;
      while (done < count) begin
         if ($urandom_range(0, 4) == 0) begin
            if ($urandom_range(0, 1)) tick_ms = $urandom;
            else tick_ms += $urandom_range(0, 3);
            send_tick(12'($urandom), 12'($urandom), 1'($urandom));
            done++;
         end else begin
            if ($urandom_range(0, 3) == 0) begin
               a   = '1;
               b   = '1;
               pin = 1'b1;
            end else begin
               a   = pick_a();
               b   = pick_b();
               pin = ($urandom_range(0, 3) != 0);
            end
            hold = $urandom_range(2, 8);
            for (k = 0; k < hold; k++) begin
               if ($urandom_range(0, 9) == 0) send_tick(pick_a(), pick_b(), pin);
               else send_tick(a, b, pin);
               tick_ms += $urandom_range(0, settle / 2 + 2);
               done++;
            end
         end
      end
   endtask

   initial begin
      int i;
      bounds[0] = RST_LADDER_A_TOP;
      bounds[1] = RST_LADDER_A_T1;
      bounds[2] = RST_LADDER_A_T2;
      bounds[3] = RST_LADDER_A_T3;
      bounds[4] = RST_LADDER_B_TOP;
      bounds[5] = RST_LADDER_B_T1;
      settle    = RST_DEBOUNCE_MS;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: band edges at reset thresholds, stamps wrapping through zero
      tick_ms = 32'hFFFF_FFC0;
      for (i = 0; i < 12; i++) begin
         send_tick(DIR_A[i], DIR_B[i], DIR_PIN[i]);
         tick_ms += DIR_GAP[i];
         send_tick(DIR_A[i], DIR_B[i], DIR_PIN[i]);
         tick_ms += 1;
      end

      // ordered thresholds, short debounce; receiver stalls long at the start
      wait_drained();
      program_ordered(16'($urandom_range(0, 20)));
      hold_off_req = 1'b1;
      run_ticks(180);

      // all-zero thresholds, zero debounce
      wait_drained();
      program_regs('0, '0, '0, '0, '0, '0, '0);
      run_ticks(150);

      // all-ones thresholds, longest debounce
      wait_drained();
      program_regs('1, '1, '1, '1, '1, '1, '1);
      tick_ms = $urandom;
      run_ticks(150);

      // thresholds in random order: overlapping and empty bands
      wait_drained();
      program_regs(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                   12'($urandom), 12'($urandom), 16'($urandom_range(0, 50)));
      run_ticks(180);

      // reset thresholds, 1 ms debounce, no idling on either side
      wait_drained();
      program_regs(RST_LADDER_A_TOP, RST_LADDER_A_T1, RST_LADDER_A_T2, RST_LADDER_A_T3,
                   RST_LADDER_B_TOP, RST_LADDER_B_T1, 16'd1);
      quiet = 1'b1;
      run_ticks(180);
      quiet = 1'b0;

      // ordered thresholds, long debounce
      wait_drained();
      program_ordered(16'($urandom_range(100, 65535)));
      run_ticks(150);

      // ordered thresholds, debounce anywhere in range
      wait_drained();
      program_ordered(16'($urandom));
      run_ticks(260);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("adc_ladder_button_debouncer_tb passed");
      end else begin
         $display("adc_ladder_button_debouncer_tb failed");
      end
      $finish;
   end

endmodule
